[rtl/deq_pkg.sv]
// deq_pkg: request codes, status codes and shared widths for the deque
// depends on: nothing

package deq_pkg;

    // request and response field widths fixed by the request and response format
    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;

    // request codes
    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_PEEK_FRONT = 3'd4;
    localparam logic [FUNC_W-1:0] FN_PEEK_BACK  = 3'd5;
    localparam logic [FUNC_W-1:0] FN_COUNT      = 3'd6;

    // response status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic accept;    // request taken this cycle
        logic load_out;  // move pending result into output register
    } t_dp_cmd;

endpackage

[rtl/deq_if.sv]
// deq_req_if / deq_rsp_if: valid/ready channels for requests and responses
// depends on: deq_pkg

interface deq_req_if #(
    parameter int DATA_WIDTH = 32
);
    logic                             valid;
    logic                             ready;
    logic [deq_pkg::FUNC_W-1:0]       func;
    logic signed [DATA_WIDTH-1:0]     push_value;

    modport source (output valid, output func, output push_value, input ready);
    modport sink   (input valid, input func, input push_value, output ready);
endinterface

interface deq_rsp_if #(
    parameter int DATA_WIDTH = 32,
    parameter int COUNT_W    = 5
);
    logic                             valid;
    logic                             ready;
    logic signed [DATA_WIDTH-1:0]     read_value;
    logic [deq_pkg::STATUS_W-1:0]     status;
    logic [COUNT_W-1:0]               count;

    modport source (output valid, output read_value, output status, output count,
                    input ready);
    modport sink   (input valid, input read_value, input status, input count,
                    output ready);
endinterface

[rtl/deq_ctrl.sv]
// deq_ctrl: request sequencing, input ready and output valid
// depends on: deq_pkg

module deq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output deq_pkg::t_dp_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic out_free;

    // output register can take a result this cycle
    assign out_free = !r_out_valid || i_out_ready;

    // next state and commands
    always_comb begin
        n_state         = r_state;
        n_out_valid     = r_out_valid;
        o_cmd.accept    = 1'b0;
        o_cmd.load_out  = 1'b0;
        o_in_ready      = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_READ;
                end
            end
            S_READ: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[rtl/deq_datapath.sv]
// deq_datapath: ring store, head/tail pointers, entry count and output register
// depends on: deq_pkg

module deq_datapath #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int PTR_W      = 4,
    parameter int COUNT_W    = 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  deq_pkg::t_dp_cmd             i_cmd,
    input  logic [deq_pkg::FUNC_W-1:0]   i_func,
    input  logic [DATA_WIDTH-1:0]        i_push_value,
    output logic [DATA_WIDTH-1:0]        o_read_value,
    output logic [deq_pkg::STATUS_W-1:0] o_status,
    output logic [COUNT_W-1:0]           o_count
);

    localparam logic [DATA_WIDTH-1:0] MIN_VAL  = DATA_WIDTH'(1) << (DATA_WIDTH - 1);
    localparam logic [PTR_W-1:0]      LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [COUNT_W-1:0]    FULL_CNT = COUNT_W'(DEPTH);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    logic [PTR_W-1:0]      r_head, n_head;
    logic [PTR_W-1:0]      r_tail, n_tail;
    logic [COUNT_W-1:0]    r_count, n_count;
    logic [deq_pkg::STATUS_W-1:0] r_pend_status, n_pend_status;
    logic                  r_pend_mem, n_pend_mem;
    logic                  r_pend_min, n_pend_min;

    logic [DATA_WIDTH-1:0]        r_out_value;
    logic [deq_pkg::STATUS_W-1:0] r_out_status;
    logic [COUNT_W-1:0]           r_out_count;

    logic [PTR_W-1:0] head_prev, head_next, tail_prev, tail_next;
    logic [PTR_W-1:0] mem_addr;
    logic             mem_we, mem_re;
    logic             is_full, is_empty;

    // ring pointer neighbors with wrap
    assign head_prev = (r_head == '0) ? LAST_PTR : r_head - 1'b1;
    assign head_next = (r_head == LAST_PTR) ? '0 : r_head + 1'b1;
    assign tail_prev = (r_tail == '0) ? LAST_PTR : r_tail - 1'b1;
    assign tail_next = (r_tail == LAST_PTR) ? '0 : r_tail + 1'b1;

    assign is_full  = (r_count == FULL_CNT);
    assign is_empty = (r_count == '0);

    // request decode
    always_comb begin
        n_head        = r_head;
        n_tail        = r_tail;
        n_count       = r_count;
        n_pend_status = deq_pkg::ST_OK;
        n_pend_mem    = 1'b0;
        n_pend_min    = 1'b0;
        mem_addr      = r_head;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        unique case (i_func) inside
            deq_pkg::FN_PUSH_FRONT, deq_pkg::FN_PUSH_BACK: begin
                if (is_full) begin
                    n_pend_status = deq_pkg::ST_FULL;
                end else begin
                    mem_we  = 1'b1;
                    n_count = r_count + 1'b1;
                    if (i_func == deq_pkg::FN_PUSH_FRONT) begin
                        n_head   = head_prev;
                        mem_addr = head_prev;
                    end else begin
                        mem_addr = r_tail;
                        n_tail   = tail_next;
                    end
                end
            end
            deq_pkg::FN_POP_FRONT, deq_pkg::FN_POP_BACK,
            deq_pkg::FN_PEEK_FRONT, deq_pkg::FN_PEEK_BACK: begin
                if (is_empty) begin
                    n_pend_status = deq_pkg::ST_EMPTY;
                    n_pend_min    = 1'b1;
                end else begin
                    mem_re     = 1'b1;
                    n_pend_mem = 1'b1;
                    if (i_func == deq_pkg::FN_POP_FRONT ||
                        i_func == deq_pkg::FN_PEEK_FRONT) begin
                        mem_addr = r_head;
                    end else begin
                        mem_addr = tail_prev;
                    end
                    if (i_func == deq_pkg::FN_POP_FRONT) begin
                        n_head  = head_next;
                        n_count = r_count - 1'b1;
                    end else if (i_func == deq_pkg::FN_POP_BACK) begin
                        n_tail  = tail_prev;
                        n_count = r_count - 1'b1;
                    end
                end
            end
            default: begin
                // count request and unused code
                n_pend_status = deq_pkg::ST_OK;
            end
        endcase
    end

    // ring store, one access per request, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && mem_we) begin
            mem[mem_addr] <= i_push_value;
        end
        if (i_cmd.accept && mem_re) begin
            r_rdata <= mem[mem_addr];
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_cmd.accept) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // pending result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pend_status <= n_pend_status;
            r_pend_mem    <= n_pend_mem;
            r_pend_min    <= n_pend_min;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (r_pend_mem) begin
                r_out_value <= r_rdata;
            end else if (r_pend_min) begin
                r_out_value <= MIN_VAL;
            end else begin
                r_out_value <= '0;
            end
            r_out_status <= r_pend_status;
            r_out_count  <= r_count;
        end
    end

    assign o_read_value = r_out_value;
    assign o_status     = r_out_status;
    assign o_count      = r_out_count;

endmodule

[rtl/double_ended_queue.sv]
// double_ended_queue: top level of the ring-buffer deque
// depends on: deq_pkg, deq_if, deq_ctrl, deq_datapath
//
//   channel  | dir | payload                     | handshake
//   ---------+-----+-----------------------------+-----------------------
//   i_req    | in  | func, push_value            | valid/ready, sink
//   o_rsp    | out | read_value, status, count   | valid/ready, source
//
// a request is accepted in S_IDLE, which does its ring store access and pointer
// update, if any; in S_READ, once the output register is free, the registered read
// data moves into the output register. no new request is taken in S_READ.
// reset (i_rst_n low, synchronous) empties the queue; store contents stay.
// a stalled response holds in the output register; the next request is taken
// meanwhile and waits in the datapath until the output register frees.

module double_ended_queue #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    deq_req_if.sink       i_req,
    deq_rsp_if.source     o_rsp
);

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);

    deq_pkg::t_dp_cmd cmd;

    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    deq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .PTR_W      (PTR_W),
        .COUNT_W    (COUNT_W)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_func       (i_req.func),
        .i_push_value (i_req.push_value),
        .o_read_value (o_rsp.read_value),
        .o_status     (o_rsp.status),
        .o_count      (o_rsp.count)
    );

endmodule
